>>> hw/rtl/eltf_pkg.sv
`default_nettype none
package eltf_pkg;

  localparam int TRIG_FRAC_DEF = 20;
  localparam int POS_FRAC_DEF  = 8;

  localparam int COORD_W = 31;
  localparam int COEF_W  = 22;
  localparam int ROT_W   = 44;
  localparam int DIFF_W  = 32;
  localparam int PROD_W  = 54;
  localparam int SUM_W   = 56;
  localparam int MAG_W   = 36;
  localparam int CM_W    = 33;
  localparam int QUO_W   = 32;
  localparam int COMP_W  = 35;
  localparam int OUT_W   = 32;
  localparam int NAXIS   = 3;
  localparam int NPROD   = 8;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int IDX_W   = 3;

  // floor(2^MAG_W / 25): quotient estimate is exact or one low for MAG_W-bit values
  localparam int                DIVISOR  = 25;
  localparam logic [QUO_W-1:0]  RECIP_25 = 32'd2748779069;

  localparam int MODE_METRES = 0;
  localparam int MODE_NED    = 1;

  localparam logic [IDX_W-1:0] REG_REF_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_REF_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_REF_Z    = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROT_ROW0 = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROT_ROW1 = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROT_MIX  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ROT_ROW2 = 3'd6;
  localparam logic [IDX_W-1:0] REG_OUT_MODE = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    logic signed [COORD_W-1:0] ref_z;
    logic [ROT_W-1:0]          rot_row0;
    logic [ROT_W-1:0]          rot_row1_a;
    logic [ROT_W-1:0]          rot_mixed;
    logic [ROT_W-1:0]          rot_row2_b;
    logic [1:0]                out_mode;
  } cfg_t;

  function automatic logic signed [COEF_W-1:0] coef_lo(input logic [ROT_W-1:0] r);
    coef_lo = r[COEF_W-1:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_hi(input logic [ROT_W-1:0] r);
    coef_hi = r[ROT_W-1:COEF_W];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/eltf_cfg.sv
`default_nettype none
module eltf_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eltf_pkg::ADDR_W-1:0] paddr,
  input  logic [eltf_pkg::DATA_W-1:0] pwdata,
  output logic [eltf_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output eltf_pkg::cfg_t              cfg
);
  import eltf_pkg::*;

  cfg_t             cfg_r;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_REF_X:    cfg_r.ref_x      <= pwdata[COORD_W-1:0];
        REG_REF_Y:    cfg_r.ref_y      <= pwdata[COORD_W-1:0];
        REG_REF_Z:    cfg_r.ref_z      <= pwdata[COORD_W-1:0];
        REG_ROT_ROW0: cfg_r.rot_row0   <= pwdata[ROT_W-1:0];
        REG_ROT_ROW1: cfg_r.rot_row1_a <= pwdata[ROT_W-1:0];
        REG_ROT_MIX:  cfg_r.rot_mixed  <= pwdata[ROT_W-1:0];
        REG_ROT_ROW2: cfg_r.rot_row2_b <= pwdata[ROT_W-1:0];
        REG_OUT_MODE: cfg_r.out_mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REF_X:    prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_r.ref_x};
      REG_REF_Y:    prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_r.ref_y};
      REG_REF_Z:    prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_r.ref_z};
      REG_ROT_ROW0: prdata = {{(DATA_W-ROT_W){1'b0}}, cfg_r.rot_row0};
      REG_ROT_ROW1: prdata = {{(DATA_W-ROT_W){1'b0}}, cfg_r.rot_row1_a};
      REG_ROT_MIX:  prdata = {{(DATA_W-ROT_W){1'b0}}, cfg_r.rot_mixed};
      REG_ROT_ROW2: prdata = {{(DATA_W-ROT_W){1'b0}}, cfg_r.rot_row2_b};
      REG_OUT_MODE: prdata = {{(DATA_W-2){1'b0}}, cfg_r.out_mode};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/eltf_rotate.sv
`default_nettype none
module eltf_rotate #(
  parameter int TRIG_FRAC = eltf_pkg::TRIG_FRAC_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  eltf_pkg::cfg_t                                    cfg,
  input  logic                                              up_valid,
  output logic                                              up_ready,
  input  logic signed [eltf_pkg::COORD_W-1:0]               pos_x,
  input  logic signed [eltf_pkg::COORD_W-1:0]               pos_y,
  input  logic signed [eltf_pkg::COORD_W-1:0]               pos_z,
  output logic                                              dn_valid,
  input  logic                                              dn_ready,
  output logic [eltf_pkg::NAXIS-1:0][eltf_pkg::SUM_W-1:0]   row
);
  import eltf_pkg::*;

  logic                     s1_vld_r, s2_vld_r, s3_vld_r;
  logic                     rdy1, rdy2, rdy3;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [PROD_W-1:0] p_r   [NPROD];
  logic signed [PROD_W-1:0] p_nxt [NPROD];
  logic signed [SUM_W-1:0]  sum_e, sum_n, sum_u;
  logic [NAXIS-1:0][SUM_W-1:0] row_r, row_nxt;

  // a stage takes a word when it is empty or its word moves on
  assign rdy3     = !s3_vld_r || dn_ready;
  assign rdy2     = !s2_vld_r || rdy3;
  assign rdy1     = !s1_vld_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = s3_vld_r;
  assign row      = row_r;

  assign dx_nxt = DIFF_W'(pos_x) - DIFF_W'(cfg.ref_x);
  assign dy_nxt = DIFF_W'(pos_y) - DIFF_W'(cfg.ref_y);
  assign dz_nxt = DIFF_W'(pos_z) - DIFF_W'(cfg.ref_z);

  // matrix entry 2 is zero, so east has two terms
  assign p_nxt[0] = dx_r * coef_lo(cfg.rot_row0);
  assign p_nxt[1] = dy_r * coef_hi(cfg.rot_row0);
  assign p_nxt[2] = dx_r * coef_lo(cfg.rot_row1_a);
  assign p_nxt[3] = dy_r * coef_hi(cfg.rot_row1_a);
  assign p_nxt[4] = dz_r * coef_lo(cfg.rot_mixed);
  assign p_nxt[5] = dx_r * coef_hi(cfg.rot_mixed);
  assign p_nxt[6] = dy_r * coef_lo(cfg.rot_row2_b);
  assign p_nxt[7] = dz_r * coef_hi(cfg.rot_row2_b);

  assign sum_e = SUM_W'(p_r[0]) + SUM_W'(p_r[1]);
  assign sum_n = SUM_W'(p_r[2]) + SUM_W'(p_r[3]) + SUM_W'(p_r[4]);
  assign sum_u = SUM_W'(p_r[5]) + SUM_W'(p_r[6]) + SUM_W'(p_r[7]);

  assign row_nxt[0] = sum_e >>> TRIG_FRAC;
  assign row_nxt[1] = sum_n >>> TRIG_FRAC;
  assign row_nxt[2] = sum_u >>> TRIG_FRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_vld_r <= up_valid;
      end
      if (rdy2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (rdy3) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
    if (rdy2 && s1_vld_r) begin
      for (int i = 0; i < NPROD; i++) begin
        p_r[i] <= p_nxt[i];
      end
    end
    if (rdy3 && s2_vld_r) begin
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/eltf_scale.sv
`default_nettype none
module eltf_scale #(
  parameter int POS_FRAC = eltf_pkg::POS_FRAC_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             metres,
  input  logic                                             up_valid,
  output logic                                             up_ready,
  input  logic [eltf_pkg::NAXIS-1:0][eltf_pkg::SUM_W-1:0]  row,
  output logic                                             dn_valid,
  input  logic                                             dn_ready,
  output logic [eltf_pkg::NAXIS-1:0][eltf_pkg::COMP_W-1:0] comp
);
  import eltf_pkg::*;

  localparam int SH      = POS_FRAC - 2;
  localparam int MET_LIM = MAG_W - SH;
  localparam int PW      = MAG_W + QUO_W;
  localparam int RES_W   = CM_W + 1;

  logic s4_vld_r, s5_vld_r, s6_vld_r;
  logic rdy4, rdy5, rdy6;

  logic [NAXIS-1:0]             neg4_r, big4_r, neg4_nxt, big4_nxt;
  logic [NAXIS-1:0][MAG_W-1:0]  mag4_r, mag4_nxt;
  logic [NAXIS-1:0]             neg5_r, big5_r;
  logic [NAXIS-1:0][MAG_W-1:0]  mag5_r;
  logic [NAXIS-1:0][QUO_W-1:0]  q5_r, q5_nxt;
  logic [NAXIS-1:0][COMP_W-1:0] comp_r, comp_nxt;

  assign rdy6     = !s6_vld_r || dn_ready;
  assign rdy5     = !s5_vld_r || rdy6;
  assign rdy4     = !s4_vld_r || rdy5;
  assign up_ready = rdy4;
  assign dn_valid = s6_vld_r;
  assign comp     = comp_r;

  // magnitude and range check; anything flagged big saturates after any negation
  always_comb begin
    logic [SUM_W-1:0] m;
    for (int i = 0; i < NAXIS; i++) begin
      neg4_nxt[i] = row[i][SUM_W-1];
      m           = neg4_nxt[i] ? -row[i] : row[i];
      big4_nxt[i] = metres ? ((m >> MET_LIM) != '0) : ((m >> CM_W) != '0);
      mag4_nxt[i] = metres ? (m[MAG_W-1:0] << SH) : m[MAG_W-1:0];
    end
  end

  // reciprocal multiply: quotient estimate, one low at most
  always_comb begin
    logic [PW-1:0] prod;
    for (int i = 0; i < NAXIS; i++) begin
      prod      = PW'(mag4_r[i]) * PW'(RECIP_25);
      q5_nxt[i] = prod[PW-1:MAG_W];
    end
  end

  // correct the estimate, pick units, restore sign
  always_comb begin
    logic [MAG_W-1:0] rem;
    logic             bump;
    logic [RES_W-1:0] res;
    for (int i = 0; i < NAXIS; i++) begin
      rem  = mag5_r[i] - (MAG_W'(q5_r[i]) * MAG_W'(DIVISOR));
      bump = rem >= MAG_W'(DIVISOR);
      if (big5_r[i]) begin
        res = RES_W'(1) << CM_W;
      end else if (metres) begin
        res = RES_W'(q5_r[i]) + RES_W'(bump);
      end else begin
        res = RES_W'(mag5_r[i][CM_W-1:0]);
      end
      comp_nxt[i] = neg5_r[i] ? -COMP_W'(res) : COMP_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      if (rdy4) begin
        s4_vld_r <= up_valid;
      end
      if (rdy5) begin
        s5_vld_r <= s4_vld_r;
      end
      if (rdy6) begin
        s6_vld_r <= s5_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && up_valid) begin
      neg4_r <= neg4_nxt;
      big4_r <= big4_nxt;
      mag4_r <= mag4_nxt;
    end
    if (rdy5 && s4_vld_r) begin
      neg5_r <= neg4_r;
      big5_r <= big4_r;
      mag5_r <= mag4_r;
      q5_r   <= q5_nxt;
    end
    if (rdy6 && s5_vld_r) begin
      comp_r <= comp_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/eltf_frame.sv
`default_nettype none
module eltf_frame (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             ned,
  input  logic                                             up_valid,
  output logic                                             up_ready,
  input  logic [eltf_pkg::NAXIS-1:0][eltf_pkg::COMP_W-1:0] comp,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output logic signed [eltf_pkg::OUT_W-1:0]                out_x,
  output logic signed [eltf_pkg::OUT_W-1:0]                out_y,
  output logic signed [eltf_pkg::OUT_W-1:0]                out_z,
  output logic                                             out_overflow
);
  import eltf_pkg::*;

  localparam logic signed [COMP_W-1:0] SAT_HI = COMP_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [COMP_W-1:0] SAT_LO = ~SAT_HI;

  logic                     vld_r;
  logic signed [OUT_W-1:0]  x_r, y_r, z_r;
  logic                     ovf_r;
  logic signed [COMP_W-1:0] v [NAXIS];
  logic signed [OUT_W-1:0]  s [NAXIS];
  logic                     ovf_nxt;

  assign up_ready     = !vld_r || !out_stall;
  assign out_valid    = vld_r;
  assign out_x        = x_r;
  assign out_y        = y_r;
  assign out_z        = z_r;
  assign out_overflow = ovf_r;

  // NED: swap the horizontal axes and flip up to down
  always_comb begin
    v[0] = ned ? comp[1] : comp[0];
    v[1] = ned ? comp[0] : comp[1];
    v[2] = ned ? -comp[2] : comp[2];
  end

  always_comb begin
    ovf_nxt = 1'b0;
    for (int i = 0; i < NAXIS; i++) begin
      if (v[i] > SAT_HI) begin
        s[i]    = SAT_HI[OUT_W-1:0];
        ovf_nxt = 1'b1;
      end else if (v[i] < SAT_LO) begin
        s[i]    = SAT_LO[OUT_W-1:0];
        ovf_nxt = 1'b1;
      end else begin
        s[i] = v[i][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r   <= s[0];
      y_r   <= s[1];
      z_r   <= s[2];
      ovf_r <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ecef_to_local_tangent_frame_core.sv
// channel   | ports                                 | word
// ----------+---------------------------------------+--------------------------------
// in        | in_valid, in_stall                    | in_pos_x, in_pos_y, in_pos_z
// out       | out_valid, out_stall                  | out_x, out_y, out_z, out_overflow
// cfg (APB) | psel, penable, pwrite, pready         | paddr, pwdata, prdata
//
// One word in per cycle while in_stall is low; each stage below ends in a register, the last being the output register.
// Stages: subtract, multiply, row sum, range, reciprocal multiply, divide fix, frame.
// Reset is synchronous on rst_n and empties the pipeline; config registers clear to 0.
// out_stall holds the output word; bubbles inside still close up, so in_stall rises
// only when all seven stages hold words.
`default_nettype none
module ecef_to_local_tangent_frame_core #(
  parameter int TRIG_FRAC = eltf_pkg::TRIG_FRAC_DEF,
  parameter int POS_FRAC  = eltf_pkg::POS_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [eltf_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [eltf_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [eltf_pkg::COORD_W-1:0] in_pos_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [eltf_pkg::OUT_W-1:0]   out_x,
  output logic signed [eltf_pkg::OUT_W-1:0]   out_y,
  output logic signed [eltf_pkg::OUT_W-1:0]   out_z,
  output logic                                out_overflow,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [eltf_pkg::ADDR_W-1:0]         paddr,
  input  logic [eltf_pkg::DATA_W-1:0]         pwdata,
  output logic [eltf_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import eltf_pkg::*;

  cfg_t                        cfg;
  logic                        in_ready;
  logic                        rot_vld, rot_rdy;
  logic [NAXIS-1:0][SUM_W-1:0] row;
  logic                        scl_vld, scl_rdy;
  logic [NAXIS-1:0][COMP_W-1:0] comp;

  assign in_stall = !in_ready;

  eltf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eltf_rotate #(
    .TRIG_FRAC (TRIG_FRAC)
  ) u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .pos_z    (in_pos_z),
    .dn_valid (rot_vld),
    .dn_ready (rot_rdy),
    .row      (row)
  );

  eltf_scale #(
    .POS_FRAC (POS_FRAC)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .metres   (cfg.out_mode[MODE_METRES]),
    .up_valid (rot_vld),
    .up_ready (rot_rdy),
    .row      (row),
    .dn_valid (scl_vld),
    .dn_ready (scl_rdy),
    .comp     (comp)
  );

  eltf_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .ned          (cfg.out_mode[MODE_NED]),
    .up_valid     (scl_vld),
    .up_ready     (scl_rdy),
    .comp         (comp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_overflow (out_overflow)
  );

endmodule
`default_nettype wire

>>> hw/rtl/eltf_check.sv
`default_nettype none
module eltf_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [eltf_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [eltf_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [eltf_pkg::COORD_W-1:0] in_pos_z,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [eltf_pkg::OUT_W-1:0]   out_x,
  input  logic signed [eltf_pkg::OUT_W-1:0]   out_y,
  input  logic signed [eltf_pkg::OUT_W-1:0]   out_z,
  input  logic                                out_overflow,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pready
);
  import eltf_pkg::*;

  localparam logic signed [OUT_W-1:0] MAX_V = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] MIN_V = {1'b1, {(OUT_W-1){1'b0}}};

  // the pipeline backs up to the input only behind a held output word
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output not held");

  // a flagged word carries at least one clamped component
  a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_x == MAX_V || out_x == MIN_V || out_y == MAX_V || out_y == MIN_V ||
       out_z == MAX_V || out_z == MIN_V))
    else $error("overflow set without a saturated component");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) &&
       $stable(out_overflow)))
    else $error("stalled output word changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_pos_x) && $stable(in_pos_y) && $stable(in_pos_z)))
    else $error("stalled input word changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable) |-> pready)
    else $error("config access not completed in one cycle");

endmodule

bind ecef_to_local_tangent_frame_core eltf_check u_eltf_check (.*);
`default_nettype wire
